// File: rtl/amde_pkg.sv
package amde_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int WEIGHT_BITS_DEF  = 16;

  localparam int VC_W     = 7;
  localparam int DEGREE_W = 7;
  localparam logic [DEGREE_W-1:0] DEG_CAP = 7'd126;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [1:0] REG_VERTEX_COUNT = 2'd0;
  localparam logic [1:0] REG_DIRECTED     = 2'd1;
  localparam logic [1:0] REG_WEIGHTED     = 2'd2;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [6:0]         from_vertex;
    logic [6:0]         to_vertex;
    logic signed [15:0] edge_weight;
  } req_t;

  typedef struct packed {
    logic [DEGREE_W-1:0] degree;
    logic                range_error;
  } rsp_t;

  // control from the sequencer to the shared accumulator
  typedef struct packed {
    logic clr;
    logic add;
    logic sum_mode;
  } acc_ctl_t;

endpackage

// File: rtl/amde_ram.sv
module amde_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/amde_acc.sv
module amde_acc #(
  parameter int WEIGHT_BITS = amde_pkg::WEIGHT_BITS_DEF,
  parameter int IDX_W       = 6
) (
  input  logic                          clk,
  input  amde_pkg::acc_ctl_t            ctl,
  input  logic signed [WEIGHT_BITS-1:0] data,
  output logic [amde_pkg::DEGREE_W-1:0] degree
);

  localparam int ACC_W = (WEIGHT_BITS + IDX_W + 2 > 8) ? WEIGHT_BITS + IDX_W + 2 : 8;

  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] inc;

  always_comb begin
    if (ctl.sum_mode) begin
      inc = ACC_W'(data);
    end else if (data != '0) begin
      inc = ACC_W'(1);
    end else begin
      inc = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc <= '0;
    end else if (ctl.add) begin
      acc <= acc + inc;
    end
  end

  // clamp to 0 .. cap
  always_comb begin
    if (acc[ACC_W-1]) begin
      degree = '0;
    end else if (acc > ACC_W'(amde_pkg::DEG_CAP)) begin
      degree = amde_pkg::DEG_CAP;
    end else begin
      degree = amde_pkg::DEGREE_W'(acc);
    end
  end

endmodule

// File: rtl/adjacency_matrix_degree_engine_unit.sv
// Add edge writes (from,to), plus (to,from) when undirected; clear wipes the
// n*n active block; query reads row, plus column if directed (n = active vertices).
// One item at a time: the next transfer is taken only after the last one is done.
// A result waiting in the output register does not block the next transfer.
// Reset (rst, synchronous) clears the whole matrix, all
// (2**clog2(MAX_VERTICES))**2 words (4096 by default), before req_ready rises.
module adjacency_matrix_degree_engine_unit #(
  parameter int MAX_VERTICES = amde_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = amde_pkg::WEIGHT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  amde_pkg::req_t               req,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output amde_pkg::rsp_t               rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [amde_pkg::PADDR_W-1:0] paddr,
  input  logic [amde_pkg::PDATA_W-1:0] pwdata,
  output logic [amde_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  localparam int IDX_W  = $clog2(MAX_VERTICES);
  localparam int ADDR_W = 2 * IDX_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int NW     = (CNT_W > amde_pkg::VC_W) ? CNT_W : amde_pkg::VC_W;

  typedef enum logic [6:0] {
    ST_WIPE   = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_WRITE2 = 7'b0000100,
    ST_ROW    = 7'b0001000,
    ST_COL    = 7'b0010000,
    ST_DRAIN  = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_t;

  state_t state;

  // configuration
  logic [amde_pkg::VC_W-1:0] vertex_count;
  logic                      directed_mode;
  logic                      weighted_mode;
  logic                      cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count  <= amde_pkg::VC_W'(1);
      directed_mode <= 1'b0;
      weighted_mode <= 1'b0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        amde_pkg::REG_VERTEX_COUNT: vertex_count  <= pwdata[amde_pkg::VC_W-1:0];
        amde_pkg::REG_DIRECTED:     directed_mode <= pwdata[0];
        amde_pkg::REG_WEIGHTED:     weighted_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      amde_pkg::REG_VERTEX_COUNT: prdata = amde_pkg::PDATA_W'(vertex_count);
      amde_pkg::REG_DIRECTED:     prdata = amde_pkg::PDATA_W'(directed_mode);
      amde_pkg::REG_WEIGHTED:     prdata = amde_pkg::PDATA_W'(weighted_mode);
      default:                    prdata = '0;
    endcase
  end

  // effective vertex count and index checks
  logic [NW-1:0]    n_vc;
  logic [NW-1:0]    n_act;
  logic [NW-1:0]    fv_w;
  logic [NW-1:0]    tv_w;
  logic             fv_ok;
  logic             tv_ok;
  logic [IDX_W-1:0] n_m1;
  logic [IDX_W-1:0] fv_idx;
  logic [IDX_W-1:0] tv_idx;

  always_comb begin
    n_vc   = NW'(vertex_count);
    n_act  = (n_vc > NW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : n_vc;
    fv_w   = NW'(req.from_vertex);
    tv_w   = NW'(req.to_vertex);
    fv_ok  = (fv_w != '0) && (fv_w <= n_act);
    tv_ok  = (tv_w != '0) && (tv_w <= n_act);
    n_m1   = IDX_W'(n_act - NW'(1));
    fv_idx = IDX_W'(req.from_vertex - 7'd1);
    tv_idx = IDX_W'(req.to_vertex - 7'd1);
  end

  // sequencer registers
  logic [IDX_W-1:0]       cnt_row;
  logic [IDX_W-1:0]       cnt_col;
  logic [IDX_W-1:0]       lim_m1;
  logic                   wipe_all;
  logic [IDX_W-1:0]       qrow;
  logic [ADDR_W-1:0]      addr2;
  logic [WEIGHT_BITS-1:0] wdata2;
  logic                   err_flag;
  logic                   sum_mode;
  logic                   tap_vld;

  logic req_fire;
  assign req_ready = (state == ST_IDLE);
  assign req_fire  = req_valid & req_ready;

  logic [WEIGHT_BITS-1:0] new_weight;
  assign new_weight = weighted_mode ? WEIGHT_BITS'(req.edge_weight) : WEIGHT_BITS'(1);

  logic add_ok;
  assign add_ok = fv_ok && tv_ok && (req.from_vertex != req.to_vertex);

  // memory port muxing
  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [WEIGHT_BITS-1:0] ram_wdata;
  logic                   ram_re;
  logic [ADDR_W-1:0]      ram_raddr;
  logic [WEIGHT_BITS-1:0] ram_rdata;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {cnt_row, cnt_col};
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = {qrow, cnt_col};
    case (state)
      ST_WIPE: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        if (req_fire && (req.op == amde_pkg::OP_ADD) && add_ok) begin
          ram_we    = 1'b1;
          ram_waddr = {fv_idx, tv_idx};
          ram_wdata = new_weight;
        end
      end
      ST_WRITE2: begin
        ram_we    = 1'b1;
        ram_waddr = addr2;
        ram_wdata = wdata2;
      end
      ST_ROW: begin
        ram_re = 1'b1;
      end
      ST_COL: begin
        ram_re    = 1'b1;
        ram_raddr = {cnt_col, qrow};
      end
      default: ;
    endcase
  end

  amde_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  amde_pkg::acc_ctl_t            acc_ctl;
  logic [amde_pkg::DEGREE_W-1:0] acc_degree;

  assign acc_ctl.clr      = req_fire;
  assign acc_ctl.add      = tap_vld;
  assign acc_ctl.sum_mode = sum_mode;

  amde_acc #(
    .WEIGHT_BITS (WEIGHT_BITS),
    .IDX_W       (IDX_W)
  ) u_acc (
    .clk    (clk),
    .ctl    (acc_ctl),
    .data   (ram_rdata),
    .degree (acc_degree)
  );

  logic out_free;
  assign out_free = ~rsp_valid | rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_WIPE;
      cnt_row  <= '0;
      cnt_col  <= '0;
      lim_m1   <= '1;
      wipe_all <= 1'b1;
      tap_vld  <= 1'b0;
      err_flag <= 1'b0;
      sum_mode <= 1'b0;
    end else begin
      tap_vld <= ram_re;
      case (state)
        ST_WIPE: begin
          if (cnt_col == lim_m1) begin
            cnt_col <= '0;
            if (cnt_row == lim_m1) begin
              cnt_row <= '0;
              state   <= wipe_all ? ST_IDLE : ST_FINISH;
            end else begin
              cnt_row <= cnt_row + 1'b1;
            end
          end else begin
            cnt_col <= cnt_col + 1'b1;
          end
        end
        ST_IDLE: begin
          if (req_fire) begin
            err_flag <= 1'b0;
            wipe_all <= 1'b0;
            cnt_row  <= '0;
            cnt_col  <= '0;
            lim_m1   <= n_m1;
            sum_mode <= ~directed_mode & ~weighted_mode;
            case (req.op)
              amde_pkg::OP_CLEAR: begin
                state <= (n_act == '0) ? ST_FINISH : ST_WIPE;
              end
              amde_pkg::OP_ADD: begin
                if (!add_ok) begin
                  err_flag <= 1'b1;
                  state    <= ST_FINISH;
                end else begin
                  addr2  <= {tv_idx, fv_idx};
                  wdata2 <= new_weight;
                  state  <= directed_mode ? ST_FINISH : ST_WRITE2;
                end
              end
              amde_pkg::OP_QUERY: begin
                if (!fv_ok) begin
                  err_flag <= 1'b1;
                  state    <= ST_FINISH;
                end else begin
                  qrow  <= fv_idx;
                  state <= ST_ROW;
                end
              end
              default: state <= ST_FINISH;
            endcase
          end
        end
        ST_WRITE2: begin
          state <= ST_FINISH;
        end
        ST_ROW: begin
          if (cnt_col == lim_m1) begin
            cnt_col <= '0;
            state   <= directed_mode ? ST_COL : ST_DRAIN;
          end else begin
            cnt_col <= cnt_col + 1'b1;
          end
        end
        ST_COL: begin
          if (cnt_col == lim_m1) begin
            cnt_col <= '0;
            state   <= ST_DRAIN;
          end else begin
            cnt_col <= cnt_col + 1'b1;
          end
        end
        ST_DRAIN: begin
          // last read word is folded into the accumulator this cycle
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == ST_FINISH) && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_FINISH) && out_free) begin
      rsp.degree      <= acc_degree;
      rsp.range_error <= err_flag;
    end
  end

endmodule

// File: tb/tb_adjacency_matrix_degree_engine_unit.sv
`timescale 1ns / 100ps

module tb_adjacency_matrix_degree_engine_unit;

  localparam int CYCLE_LIMIT = 8_000_000;
  localparam int N_DIRECTED = 27;
  localparam int N_PHASES = 9;
  localparam int LONG_HOLD = 400;

  typedef struct {
    bit               is_cfg;
    logic [6:0]       vc;
    bit               dir;
    bit               wtd;
    amde_pkg::req_t   item;
    bit               typed;
    amde_pkg::rsp_t   want;
  } step_t;

  typedef struct {
    int vc;
    bit dir;
    bit wtd;
    int items;
    bit steady;
  } graph_phase_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          req_valid = 1'b0;
  logic                          req_ready;
  amde_pkg::req_t                req = '0;
  logic                          rsp_valid;
  logic                          rsp_ready = 1'b0;
  amde_pkg::rsp_t                rsp;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [amde_pkg::PADDR_W-1:0]  paddr = '0;
  logic [amde_pkg::PDATA_W-1:0]  pwdata = '0;
  logic [amde_pkg::PDATA_W-1:0]  prdata;
  logic                          pready;

  // graph image and mode as the block should hold them
  logic [15:0] graph_w [0:63][0:63];
  logic [6:0]  cfg_vc = 7'd1;
  bit          cfg_dir = 1'b0;
  bit          cfg_wtd = 1'b0;

  amde_pkg::rsp_t answer_q [$];
  int   items_in = 0;
  int   results_out = 0;
  int   mismatches = 0;
  int   op_count [4] = '{0, 0, 0, 0};
  int   cycle_count = 0;
  bit   steady_flow = 1'b0;

  step_t directed_steps [N_DIRECTED] = '{
    '{1'b0, 7'd0,  1'b0, 1'b0, '{amde_pkg::OP_QUERY, 7'd1, 7'd0, 16'sd0}, 1'b1, '{7'd0, 1'b0}},
    '{1'b0, 7'd0,  1'b0, 1'b0, '{amde_pkg::OP_QUERY, 7'd0, 7'd0, 16'sd0}, 1'b1, '{7'd0, 1'b1}},
    '{1'b0, 7'd0,  1'b0, 1'b0, '{amde_pkg::OP_ADD, 7'd1, 7'd1, 16'sd3}, 1'b1, '{7'd0, 1'b1}},
    '{1'b0, 7'd0,  1'b0, 1'b0, '{amde_pkg::OP_ADD, 7'd1, 7'd2, 16'sd3}, 1'b1, '{7'd0, 1'b1}},
    '{1'b1, 7'd64, 1'b0, 1'b1, '{amde_pkg::OP_CLEAR, 7'd0, 7'd0, 16'sd0}, 1'b0, '{7'd0, 1'b0}},
    '{1'b0, 7'd0,  1'b0, 1'b0, '{amde_pkg::OP_ADD, 7'd1, 7'd64, 16'sh7FFF}, 1'b1, '{7'd0, 1'b0}},
    '{1'b0, 7'd0,  1'b0, 1'b0, '{amde_pkg::OP_ADD, 7'd64, 7'd2, 16'sh8000}, 1'b1, '{7'd0, 1'b0}},
    '{1'b0, 7'd0,  1'b0, 1'b0, '{amde_pkg::OP_ADD, 7'd3, 7'd64, 16'sd0}, 1'b1, '{7'd0, 1'b0}},
    '{1'b0, 7'd0,  1'b0, 1'b0, '{amde_pkg::OP_QUERY, 7'd64, 7'd0, 16'sd0}, 1'b0, '{7'd0, 1'b0}},
    '{1'b0, 7'd0,  1'b0, 1'b0, '{amde_pkg::OP_ADD, 7'd0, 7'd5, 16'sd9}, 1'b1, '{7'd0, 1'b1}},
    '{1'b0, 7'd0,  1'b0, 1'b0, '{amde_pkg::OP_ADD, 7'd5, 7'd0, 16'sd9}, 1'b1, '{7'd0, 1'b1}},
    '{1'b1, 7'd64, 1'b0, 1'b0, '{amde_pkg::OP_CLEAR, 7'd0, 7'd0, 16'sd0}, 1'b0, '{7'd0, 1'b0}},
    '{1'b0, 7'd0,  1'b0, 1'b0, '{amde_pkg::OP_QUERY, 7'd1, 7'd0, 16'sd0}, 1'b0, '{7'd0, 1'b0}},
    '{1'b0, 7'd0,  1'b0, 1'b0, '{amde_pkg::OP_QUERY, 7'd2, 7'd0, 16'sd0}, 1'b0, '{7'd0, 1'b0}},
    '{1'b0, 7'd0,  1'b0, 1'b0, '{amde_pkg::OP_ADD, 7'd10, 7'd20, 16'shFFFF}, 1'b1, '{7'd0, 1'b0}},
    '{1'b0, 7'd0,  1'b0, 1'b0, '{amde_pkg::OP_QUERY, 7'd10, 7'd0, 16'sd0}, 1'b0, '{7'd0, 1'b0}},
    '{1'b1, 7'd64, 1'b1, 1'b0, '{amde_pkg::OP_CLEAR, 7'd0, 7'd0, 16'sd0}, 1'b0, '{7'd0, 1'b0}},
    '{1'b0, 7'd0,  1'b0, 1'b0, '{amde_pkg::OP_ADD, 7'd5, 7'd6, 16'sd0}, 1'b1, '{7'd0, 1'b0}},
    '{1'b0, 7'd0,  1'b0, 1'b0, '{amde_pkg::OP_ADD, 7'd6, 7'd5, 16'sd0}, 1'b1, '{7'd0, 1'b0}},
    '{1'b0, 7'd0,  1'b0, 1'b0, '{amde_pkg::OP_QUERY, 7'd5, 7'd0, 16'sd0}, 1'b0, '{7'd0, 1'b0}},
    '{1'b0, 7'd0,  1'b0, 1'b0, '{amde_pkg::OP_CLEAR, 7'd0, 7'd0, 16'sd0}, 1'b1, '{7'd0, 1'b0}},
    '{1'b0, 7'd0,  1'b0, 1'b0, '{amde_pkg::OP_QUERY, 7'd64, 7'd0, 16'sd0}, 1'b1, '{7'd0, 1'b0}},
    '{1'b1, 7'd5,  1'b0, 1'b1, '{amde_pkg::OP_CLEAR, 7'd0, 7'd0, 16'sd0}, 1'b0, '{7'd0, 1'b0}},
    '{1'b0, 7'd0,  1'b0, 1'b0, '{amde_pkg::OP_QUERY, 7'd6, 7'd0, 16'sd0}, 1'b1, '{7'd0, 1'b1}},
    '{1'b0, 7'd0,  1'b0, 1'b0, '{amde_pkg::OP_ADD, 7'd2, 7'd6, 16'sd7}, 1'b1, '{7'd0, 1'b1}},
    '{1'b0, 7'd0,  1'b0, 1'b0, '{amde_pkg::OP_ADD, 7'd2, 7'd5, 16'sd7}, 1'b1, '{7'd0, 1'b0}},
    '{1'b0, 7'd0,  1'b0, 1'b0, '{amde_pkg::OP_QUERY, 7'd5, 7'd0, 16'sd0}, 1'b0, '{7'd0, 1'b0}}
  };

  // stale entries are kept across mode changes on purpose
  graph_phase_t phases [N_PHASES] = '{
    '{64, 1'b0, 1'b0, 70, 1'b0},
    '{1,  1'b0, 1'b0, 25, 1'b0},
    '{6,  1'b1, 1'b0, 80, 1'b0},
    '{12, 1'b0, 1'b1, 80, 1'b0},
    '{4,  1'b1, 1'b1, 80, 1'b0},
    '{64, 1'b1, 1'b1, 70, 1'b0},
    '{9,  1'b0, 1'b0, 80, 1'b1},
    '{2,  1'b0, 1'b1, 40, 1'b0},
    '{30, 1'b1, 1'b0, 70, 1'b0}
  };

  adjacency_matrix_degree_engine_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               answer_q.size());
      $display("FAIL");
      $finish;
    end
  end

  function automatic amde_pkg::rsp_t graph_step(input amde_pkg::req_t it);
    amde_pkg::rsp_t res;
    int   n;
    int   fv;
    int   tv;
    int   acc;
    logic [15:0] w;
    res = '0;
    n = (cfg_vc > 7'd64) ? 64 : int'(cfg_vc);
    fv = it.from_vertex;
    tv = it.to_vertex;
    case (it.op)
      amde_pkg::OP_CLEAR: begin
        for (int r = 0; r < n; r++)
          for (int c = 0; c < n; c++)
            graph_w[r][c] = '0;
      end
      amde_pkg::OP_ADD: begin
        if (fv < 1 || fv > n || tv < 1 || tv > n || fv == tv) begin
          res.range_error = 1'b1;
        end else begin
          w = cfg_wtd ? it.edge_weight : 16'd1;
          graph_w[fv-1][tv-1] = w;
          if (!cfg_dir)
            graph_w[tv-1][fv-1] = w;
        end
      end
      amde_pkg::OP_QUERY: begin
        if (fv < 1 || fv > n) begin
          res.range_error = 1'b1;
        end else begin
          acc = 0;
          for (int i = 0; i < n; i++) begin
            if (cfg_dir)
              acc += int'(graph_w[fv-1][i] != 0) + int'(graph_w[i][fv-1] != 0);
            else if (cfg_wtd)
              acc += int'(graph_w[fv-1][i] != 0);
            else
              acc = acc + int'($signed(graph_w[fv-1][i]));
          end
          if (acc < 0)
            acc = 0;
          if (acc > int'(amde_pkg::DEG_CAP))
            acc = int'(amde_pkg::DEG_CAP);
          res.degree = 7'(acc);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // mostly well-formed edge adds and queries inside the active range, occasional clears, some broken indices
  function automatic amde_pkg::req_t random_item();
    amde_pkg::req_t it;
    int   n;
    int   r;
    logic [6:0] bad;
    n = (cfg_vc > 7'd64) ? 64 : int'(cfg_vc);
    it.from_vertex = 7'($urandom_range(0, 64));
    it.to_vertex = 7'($urandom_range(0, 64));
    r = $urandom_range(0, 99);
    if (r < 30)
      it.edge_weight = 16'($urandom_range(0, 65535));
    else if (r < 40)
      it.edge_weight = '0;
    else if (r < 46)
      it.edge_weight = 16'sh7FFF;
    else if (r < 52)
      it.edge_weight = 16'sh8000;
    else
      it.edge_weight = 16'(int'($urandom_range(0, 8)) - 4);
    r = $urandom_range(0, 99);
    if (r < ((n > 16) ? 2 : 5))
      it.op = amde_pkg::OP_CLEAR;
    else if (r < 58)
      it.op = amde_pkg::OP_ADD;
    else
      it.op = amde_pkg::OP_QUERY;
    if ($urandom_range(0, 99) < 88) begin
      it.from_vertex = 7'($urandom_range(1, n));
      if (n > 1) begin
        it.to_vertex = 7'($urandom_range(1, n - 1));
        if (it.to_vertex >= it.from_vertex)
          it.to_vertex = it.to_vertex + 7'd1;
      end
    end else begin
      bad = (n < 64) ? 7'($urandom_range(n + 1, 64)) : 7'd0;
      case ($urandom_range(0, 2))
        0: if ($urandom_range(0, 1)) it.from_vertex = '0; else it.to_vertex = '0;
        1: if ($urandom_range(0, 1)) it.from_vertex = bad; else it.to_vertex = bad;
        default: begin
          it.from_vertex = 7'($urandom_range(1, n));
          it.to_vertex = it.from_vertex;
        end
      endcase
    end
    return it;
  endfunction

  task automatic reg_write(input logic [1:0] idx, input logic [amde_pkg::PDATA_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_graph_mode(input int vc, input bit dir, input bit wtd);
    req_valid <= 1'b0;
    while (answer_q.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    reg_write(amde_pkg::REG_VERTEX_COUNT, amde_pkg::PDATA_W'(vc));
    reg_write(amde_pkg::REG_DIRECTED, amde_pkg::PDATA_W'(dir));
    reg_write(amde_pkg::REG_WEIGHTED, amde_pkg::PDATA_W'(wtd));
    cfg_vc = 7'(vc);
    cfg_dir = dir;
    cfg_wtd = wtd;
  endtask

  task automatic offer(input amde_pkg::req_t it, input bit typed,
                       input amde_pkg::rsp_t want);
    int   gap;
    int   r;
    amde_pkg::rsp_t pred;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 65)
      gap = 0;
    else if (r < 93)
      gap = $urandom_range(1, 3);
    else
      gap = $urandom_range(8, 40);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= it;
    do @(posedge clk); while (!req_ready);
    pred = graph_step(it);
    answer_q.push_back(typed ? want : pred);
    items_in++;
    op_count[it.op]++;
  endtask

  task automatic flag_mismatch(input string what, input amde_pkg::rsp_t want,
                               input amde_pkg::rsp_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0d: %s: want degree %0d err %0b, got degree %0d err %0b", cycle_count,
               what, want.degree, want.range_error, got.degree, got.range_error);
  endtask

  always @(posedge clk) begin : rsp_check
    amde_pkg::rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      results_out++;
      if (answer_q.size() == 0) begin
        flag_mismatch("result with nothing outstanding", '0, rsp);
      end else begin
        want = answer_q.pop_front();
        if (rsp.degree !== want.degree || rsp.range_error !== want.range_error)
          flag_mismatch($sformatf("result %0d", results_out), want, rsp);
      end
    end
  end

  // result side: random stalls, one long hold-off to back up the input side
  initial begin : sink
    bit held_once;
    int r;
    held_once = 1'b0;
    forever begin
      if (!held_once && items_in >= 40) begin
        held_once = 1'b1;
        rsp_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (steady_flow) begin
        rsp_ready <= 1'b1;
        @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          rsp_ready <= 1'b1;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end else if (r < 92) begin
          rsp_ready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          rsp_ready <= 1'b0;
          repeat ($urandom_range(10, 60)) @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    for (int r = 0; r < 64; r++)
      for (int c = 0; c < 64; c++)
        graph_w[r][c] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < N_DIRECTED; k++) begin
      if (directed_steps[k].is_cfg)
        set_graph_mode(int'(directed_steps[k].vc), directed_steps[k].dir,
                       directed_steps[k].wtd);
      else
        offer(directed_steps[k].item, directed_steps[k].typed, directed_steps[k].want);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      set_graph_mode(phases[p].vc, phases[p].dir, phases[p].wtd);
      steady_flow = phases[p].steady;
      repeat (phases[p].items)
        offer(random_item(), 1'b0, '0);
    end

    req_valid <= 1'b0;
    while (answer_q.size() != 0)
      @(posedge clk);
    repeat (140) @(posedge clk);

    $display("%0d transfers in, %0d results out: %0d clears, %0d edge adds, %0d queries",
             items_in, results_out, op_count[amde_pkg::OP_CLEAR],
             op_count[amde_pkg::OP_ADD], op_count[amde_pkg::OP_QUERY]);
    $display("%0d vertex count / direction / weighting settings, %0d mismatches, %0d cycles",
             N_PHASES + 4, mismatches, cycle_count);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
